// ===== design/ccd_pkg.sv =====
// Package with shared constants and types for the connected components search core.
`timescale 1ns / 1ps
package ccd_pkg;
   localparam int MaxNodes = 64;
   localparam int MaxEdges = 256;
   localparam int VW = 7;
   localparam int EAW = $clog2(MaxEdges);
   localparam int ECW = EAW + 1;
   localparam int SAW = $clog2(MaxNodes);
   localparam int SCW = SAW + 1;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_RUN = 2'd1;
   localparam logic [1:0] ACT_CLR = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic start_run;
      logic do_add;
      logic do_clear;
      logic next_seed;
      logic edge_fetch;
      logic edge_eval;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic add_ok;
      logic add_range_ok;
      logic seed_done;
      logic seed_unvisited;
      logic edges_left;
      logic found;
      logic stack_empty_after_pop;
      logic all_seen;
   } sts_type;
endpackage

// ===== design/ccd_ram.sv =====
// Generic RAM with one write port, one read port and registered read.
`timescale 1ns / 1ps
module ccd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/ccd_datapath.sv =====
// Datapath: edge store, visited marks, walk stack and result fields.
`timescale 1ns / 1ps
module ccd_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ccd_pkg::VW-1:0]   n_eff,
   input  logic [ccd_pkg::VW-1:0]   vertex_a,
   input  logic [ccd_pkg::VW-1:0]   vertex_b,
   input  ccd_pkg::cmd_type         cmd,
   output ccd_pkg::sts_type         sts,
   output logic [ccd_pkg::VW-1:0]   out_vertex,
   output logic [ccd_pkg::VW-1:0]   out_comp,
   output logic                     out_first
);
   import ccd_pkg::*;

   logic [ECW-1:0] edge_total_ff, edge_total_in;
   logic [MaxNodes:1] visited_ff, visited_in;
   logic [VW-1:0] seed_ff, seed_in;
   logic [VW-1:0] comp_ff, comp_in;
   logic [SCW-1:0] sp_ff, sp_in;
   logic [VW-1:0] cur_v_ff, cur_v_in;
   logic [ECW-1:0] cur_i_ff, cur_i_in;
   logic [VW-1:0] seen_ff, seen_in;
   logic [VW-1:0] out_vertex_ff, out_vertex_in;
   logic out_first_ff, out_first_in;

   logic [VW-1:0] ea_rd, eb_rd;
   logic [VW+ECW-1:0] st_rd, st_wd;
   logic [SAW-1:0] st_waddr, st_raddr;
   logic st_we;
   logic [VW-1:0] w;
   logic [VW-1:0] w_idx, seed_idx;
   logic adj, wfound;
   logic [SCW-1:0] sp_m1;

   ccd_ram #(.Width(VW), .Depth(MaxEdges)) u_ea (
      .clock(clock), .wr_en(cmd.do_add && sts.add_ok), .wr_addr(edge_total_ff[EAW-1:0]),
      .wr_data(vertex_a), .rd_addr(cur_i_ff[EAW-1:0]), .rd_data(ea_rd));
   ccd_ram #(.Width(VW), .Depth(MaxEdges)) u_eb (
      .clock(clock), .wr_en(cmd.do_add && sts.add_ok), .wr_addr(edge_total_ff[EAW-1:0]),
      .wr_data(vertex_b), .rd_addr(cur_i_ff[EAW-1:0]), .rd_data(eb_rd));
   ccd_ram #(.Width(VW + ECW), .Depth(MaxNodes)) u_stack (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wd),
      .rd_addr(st_raddr), .rd_data(st_rd));

   assign sp_m1 = sp_ff - SCW'(1);
   assign adj = (ea_rd == cur_v_ff) || (eb_rd == cur_v_ff);
   assign w = (ea_rd == cur_v_ff) ? eb_rd : ea_rd;
   assign w_idx = ((w == '0) || (w > VW'(MaxNodes))) ? VW'(1) : w;
   assign seed_idx = ((seed_ff == '0) || (seed_ff > VW'(MaxNodes))) ? VW'(1) : seed_ff;
   assign wfound = adj && (w != '0) && (w <= n_eff) && !visited_ff[w_idx];

   always_comb begin
      sts.add_range_ok = (vertex_a != '0) && (vertex_a <= n_eff) && (vertex_b != '0) &&
                         (vertex_b <= n_eff);
      sts.add_ok = sts.add_range_ok && (edge_total_ff != ECW'(MaxEdges));
      sts.seed_done = (seed_ff > n_eff);
      sts.seed_unvisited = !visited_ff[seed_idx];
      sts.edges_left = (cur_i_ff < edge_total_ff);
      sts.found = wfound;
      sts.stack_empty_after_pop = (sp_ff <= SCW'(1));
      sts.all_seen = (seen_ff == n_eff);
   end

   always_comb begin
      edge_total_in = edge_total_ff;
      visited_in = visited_ff;
      seed_in = seed_ff;
      comp_in = comp_ff;
      sp_in = sp_ff;
      cur_v_in = cur_v_ff;
      cur_i_in = cur_i_ff;
      seen_in = seen_ff;
      out_vertex_in = out_vertex_ff;
      out_first_in = out_first_ff;
      st_we = 1'b0;
      st_waddr = sp_m1[SAW-1:0];
      st_wd = {cur_v_ff, cur_i_ff};
      st_raddr = sp_ff >= SCW'(2) ? SAW'(sp_ff - SCW'(2)) : '0;
      if (cmd.do_clear) edge_total_in = '0;
      if (cmd.do_add && sts.add_ok) edge_total_in = edge_total_ff + ECW'(1);
      if (cmd.start_run) begin
         visited_in = '0;
         seed_in = VW'(1);
         comp_in = '0;
         sp_in = '0;
         seen_in = '0;
      end
      if (cmd.next_seed) begin
         if (sts.seed_unvisited) begin
            visited_in[seed_idx] = 1'b1;
            comp_in = comp_ff + VW'(1);
            out_vertex_in = seed_ff;
            out_first_in = 1'b1;
            seen_in = seen_ff + VW'(1);
            cur_v_in = seed_ff;
            cur_i_in = '0;
            sp_in = SCW'(1);
         end
         seed_in = seed_ff + VW'(1);
      end
      if (cmd.edge_fetch) begin
         cur_i_in = cur_i_ff + ECW'(1);
      end
      if (cmd.edge_eval && wfound) begin
         visited_in[w_idx] = 1'b1;
         out_vertex_in = w;
         out_first_in = 1'b0;
         seen_in = seen_ff + VW'(1);
         st_we = 1'b1;
         st_waddr = sp_m1[SAW-1:0];
         st_wd = {cur_v_ff, cur_i_ff};
         cur_v_in = w;
         cur_i_in = '0;
         sp_in = sp_ff + SCW'(1);
      end
      if (cmd.pop) begin
         sp_in = sp_m1;
         cur_v_in = st_rd[VW+ECW-1:ECW];
         cur_i_in = st_rd[ECW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_total_ff <= '0;
         visited_ff <= '0;
         seed_ff <= '0;
         comp_ff <= '0;
         sp_ff <= '0;
         seen_ff <= '0;
      end else begin
         edge_total_ff <= edge_total_in;
         visited_ff <= visited_in;
         seed_ff <= seed_in;
         comp_ff <= comp_in;
         sp_ff <= sp_in;
         seen_ff <= seen_in;
      end
      cur_v_ff <= cur_v_in;
      cur_i_ff <= cur_i_in;
      out_vertex_ff <= out_vertex_in;
      out_first_ff <= out_first_in;
   end

   assign out_vertex = out_vertex_ff;
   assign out_comp = comp_ff;
   assign out_first = out_first_ff;
endmodule

// ===== design/ccd_control.sv =====
// Controller state machine sequencing requests, edge scans and result hand-off.
`timescale 1ns / 1ps
module ccd_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_action,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   out_ack,
   output logic [1:0]             out_status,
   output logic                   out_last,
   input  ccd_pkg::sts_type       sts,
   output ccd_pkg::cmd_type       cmd
);
   import ccd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SEED = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_POP = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic ack_ff, ack_in;
   logic [1:0] status_ff, status_in;
   logic last_ff, last_in;
   logic take;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ack_in = ack_ff;
      status_in = status_ff;
      last_in = last_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (req_action == ACT_RUN) begin
                  cmd.start_run = 1'b1;
                  state_in = S_SEED;
               end else begin
                  cmd.do_add = (req_action == ACT_ADD);
                  cmd.do_clear = (req_action == ACT_CLR);
                  rsp_valid_in = 1'b1;
                  ack_in = 1'b1;
                  last_in = 1'b1;
                  status_in = ST_OK;
                  if (req_action == ACT_ADD && !sts.add_ok) begin
                     // Range check has priority over the full check.
                     status_in = sts.add_range_ok ? ST_FULL : ST_RANGE;
                  end
               end
            end
         end
         S_SEED: begin
            if (sts.seed_done) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.next_seed = 1'b1;
               if (sts.seed_unvisited) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            ack_in = 1'b0;
            status_in = ST_OK;
            last_in = sts.all_seen;
            state_in = sts.all_seen ? S_IDLE : S_FETCH;
         end
         S_FETCH: begin
            if (!sts.edges_left) begin
               state_in = S_POP;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.edge_fetch = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (sts.found) begin
               cmd.edge_eval = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_POP: begin
            if (sts.stack_empty_after_pop) begin
               cmd.pop = 1'b1;
               state_in = S_SEED;
            end else begin
               cmd.pop = 1'b1;
               state_in = S_FETCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ack_ff <= ack_in;
      status_ff <= status_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_ack = ack_ff;
   assign out_status = status_ff;
   assign out_last = last_ff;
endmodule

// ===== design/connected_components_dfs_core.sv =====
// Top level of the connected components depth-first search core.
`timescale 1ns / 1ps
// Edge, clear and unused requests each give one acknowledgement. A run request
// scans the edge store once per stack level: each edge is a memory read, then a
// compare, the scan holds while a result waits to be taken, and no request is
// accepted until its last result has been delivered.
module connected_components_dfs_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_node_count,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [6:0] req_vertex_a,
   input  logic [6:0] req_vertex_b,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_visited_vertex,
   output logic [6:0] rsp_component_number,
   output logic       rsp_starts_component,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);
   import ccd_pkg::*;

   logic [VW-1:0] node_count_ff;
   logic [VW-1:0] n_eff;
   cmd_type cmd;
   sts_type sts;
   logic ack;
   logic [VW-1:0] dv, dc;
   logic df;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) node_count_ff <= VW'(64);
      else if (csr_valid) node_count_ff <= csr_node_count;
   end
   assign n_eff = (node_count_ff == '0) ? VW'(1) :
                  (node_count_ff > VW'(MaxNodes)) ? VW'(MaxNodes) : node_count_ff;

   ccd_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .rsp_ready(rsp_ready), .rsp_valid(rsp_valid),
      .out_ack(ack), .out_status(rsp_status), .out_last(rsp_last), .sts(sts), .cmd(cmd));

   ccd_datapath u_dp (
      .clock(clock), .reset(reset), .n_eff(n_eff), .vertex_a(req_vertex_a),
      .vertex_b(req_vertex_b), .cmd(cmd), .sts(sts), .out_vertex(dv), .out_comp(dc),
      .out_first(df));

   assign rsp_visited_vertex = ack ? '0 : dv;
   assign rsp_component_number = ack ? '0 : dc;
   assign rsp_starts_component = ack ? 1'b0 : df;
endmodule

// ===== dv/tb_connected_components_dfs_core.sv =====
// Testbench for the connected components depth-first search core with a self-checking scoreboard.
`timescale 1ns / 1ps
module tb_connected_components_dfs_core;
   import ccd_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [6:0] vertex;
      logic [6:0] component;
      logic       opens;
      logic [1:0] status;
      logic       last;
   } walk_result_type;

   logic       clock;
   logic       reset;
   logic       csr_valid;
   logic       csr_ready;
   logic [6:0] csr_node_count;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_action;
   logic [6:0] req_vertex_a;
   logic [6:0] req_vertex_b;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [6:0] rsp_visited_vertex;
   logic [6:0] rsp_component_number;
   logic       rsp_starts_component;
   logic [1:0] rsp_status;
   logic       rsp_last;

   walk_result_type expected_q[$];
   logic [6:0] edge_from[MaxEdges];
   logic [6:0] edge_to[MaxEdges];
   int edge_count;
   logic [6:0] nodes_reg;
   int fail_count;
   int result_count;
   int request_count;
   int run_count;
   bit stall_enable;

   connected_components_dfs_core i_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_node_count(csr_node_count),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_vertex_a(req_vertex_a), .req_vertex_b(req_vertex_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_visited_vertex(rsp_visited_vertex), .rsp_component_number(rsp_component_number),
      .rsp_starts_component(rsp_starts_component), .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int active_count();
      if (nodes_reg < 1) return 1;
      if (nodes_reg > MaxNodes) return MaxNodes;
      return int'(nodes_reg);
   endfunction

   function automatic void push_result(int v, int c, bit o, logic [1:0] s, bit l);
      walk_result_type r;
      r.vertex = v[6:0];
      r.component = c[6:0];
      r.opens = o;
      r.status = s;
      r.last = l;
      expected_q = {expected_q, r};
   endfunction

   function automatic void predict_search();
      int n;
      int tally;
      int sp;
      int v;
      int i;
      int w;
      int first_idx;
      bit found;
      bit seen[MaxNodes + 1];
      int stk_v[MaxNodes];
      int stk_i[MaxNodes];
      n = active_count();
      tally = 0;
      first_idx = expected_q.size();
      for (int k = 0; k <= MaxNodes; k++) seen[k] = 1'b0;
      for (int s = 1; s <= n; s++) begin
         if (seen[s]) continue;
         tally++;
         seen[s] = 1'b1;
         push_result(s, tally, 1'b1, ST_OK, 1'b0);
         stk_v[0] = s;
         stk_i[0] = 0;
         sp = 1;
         while (sp > 0) begin
            v = stk_v[sp - 1];
            i = stk_i[sp - 1];
            w = 0;
            found = 1'b0;
            while (i < edge_count && !found) begin
               if (edge_from[i] == v) w = edge_to[i];
               else if (edge_to[i] == v) w = edge_from[i];
               else w = 0;
               i++;
               if (w >= 1 && w <= n && !seen[w]) found = 1'b1;
            end
            stk_i[sp - 1] = i;
            if (found) begin
               seen[w] = 1'b1;
               push_result(w, tally, 1'b0, ST_OK, 1'b0);
               if (sp < MaxNodes) begin
                  stk_v[sp] = w;
                  stk_i[sp] = 0;
                  sp++;
               end
            end else begin
               sp--;
            end
         end
      end
      if (expected_q.size() > first_idx) expected_q[expected_q.size() - 1].last = 1'b1;
   endfunction

   function automatic void predict_request(logic [1:0] act, logic [6:0] a, logic [6:0] b);
      int n;
      logic [1:0] st;
      n = active_count();
      if (act == ACT_RUN) begin
         predict_search();
         run_count++;
         return;
      end
      st = ST_OK;
      if (act == ACT_ADD) begin
         if (a < 1 || a > n || b < 1 || b > n) st = ST_RANGE;
         else if (edge_count >= MaxEdges) st = ST_FULL;
         else begin
            edge_from[edge_count] = a;
            edge_to[edge_count] = b;
            edge_count++;
         end
      end else if (act == ACT_CLR) begin
         edge_count = 0;
      end
      push_result(0, 0, 1'b0, st, 1'b1);
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(8, 30));
      return int'($urandom_range(1, 3));
   endfunction

   task automatic send_request(logic [1:0] act, logic [6:0] a, logic [6:0] b);
      int g;
      g = stall_enable ? gap_length() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_vertex_a <= a;
      req_vertex_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(act, a, b);
      request_count++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_node_count(logic [6:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_node_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      nodes_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (expected_q.size() == 0) begin
            $error("unexpected result vertex=%0d", rsp_visited_vertex);
            fail_count++;
         end else begin
            walk_result_type e;
            e = expected_q.pop_front();
            if (rsp_visited_vertex !== e.vertex) begin
               $error("visited_vertex expected %0d actual %0d", e.vertex, rsp_visited_vertex);
               fail_count++;
            end
            if (rsp_component_number !== e.component) begin
               $error("component_number expected %0d actual %0d", e.component,
                      rsp_component_number);
               fail_count++;
            end
            if (rsp_starts_component !== e.opens) begin
               $error("starts_component expected %0d actual %0d", e.opens,
                      rsp_starts_component);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               fail_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (!stall_enable) rsp_ready <= 1'b1;
      else if (r < 3) rsp_ready <= 1'b0;
      else if (r < 25) rsp_ready <= ~rsp_ready;
      else rsp_ready <= 1'b1;
   end

   task automatic test_directed();
      write_node_count(7'd8);
      send_request(ACT_RUN, 7'd0, 7'd0);
      send_request(ACT_ADD, 7'd1, 7'd2);
      send_request(ACT_ADD, 7'd2, 7'd3);
      send_request(ACT_ADD, 7'd5, 7'd4);
      send_request(ACT_ADD, 7'd6, 7'd6);
      send_request(ACT_ADD, 7'd8, 7'd1);
      send_request(ACT_ADD, 7'd0, 7'd3);
      send_request(ACT_ADD, 7'd9, 7'd1);
      send_request(ACT_ADD, 7'd2, 7'd127);
      send_request(ACT_UNUSED, 7'd127, 7'd127);
      send_request(ACT_RUN, 7'd0, 7'd0);
      write_node_count(7'd3);
      send_request(ACT_RUN, 7'd0, 7'd0);
      write_node_count(7'd0);
      send_request(ACT_ADD, 7'd1, 7'd1);
      send_request(ACT_RUN, 7'd0, 7'd0);
      write_node_count(7'd127);
      send_request(ACT_ADD, 7'd64, 7'd1);
      send_request(ACT_ADD, 7'd65, 7'd1);
      send_request(ACT_RUN, 7'd0, 7'd0);
      send_request(ACT_CLR, 7'd85, 7'd42);
      send_request(ACT_RUN, 7'd0, 7'd0);
   endtask

   task automatic test_random_graphs();
      int n;
      int ne;
      for (int g = 0; g < 12; g++) begin
         n = (g % 4 == 3) ? MaxNodes : int'($urandom_range(1, 16));
         write_node_count(n[6:0]);
         if (g == 6) stall_enable = 1'b0;
         if (g == 8) stall_enable = 1'b1;
         send_request(ACT_CLR, 7'($urandom), 7'($urandom));
         ne = int'($urandom_range(1, 14));
         for (int k = 0; k < ne; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(2'($urandom), 7'($urandom), 7'($urandom));
            end else begin
               send_request(ACT_ADD, 7'($urandom_range(1, n)), 7'($urandom_range(1, n)));
            end
         end
         send_request(ACT_RUN, 7'd0, 7'd0);
         if (g == 4) drain_results();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_node_count = '0;
      req_valid = 1'b0;
      req_action = ACT_ADD;
      req_vertex_a = '0;
      req_vertex_b = '0;
      rsp_ready = 1'b0;
      stall_enable = 1'b1;
      nodes_reg = 7'd64;
      edge_count = 0;
      fail_count = 0;
      result_count = 0;
      request_count = 0;
      run_count = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_graphs();
      drain_results();
      $display("Covered %0d requests and %0d searches, %0d results checked.",
               request_count, run_count, result_count);
      $display("Edge loads, bad endpoints, clears, spare codes and node count limits included.");
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #60ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
